FILE: hw/rtl/nnfd_pkg.sv
// Shared constants and helpers for the nearest-neighbour fit downscaler.
// Holds widths, register indexes and the reset values of the derived scale state.
// No dependencies.
`default_nettype none

package nnfd_pkg;

  localparam int DIM_BITS  = 12;
  localparam int FRAC_BITS = 16;
  localparam int POS_BITS  = DIM_BITS + FRAC_BITS;
  localparam int PIX_BITS  = 16;
  localparam int CNT_BITS  = $clog2(POS_BITS);
  localparam int IDX_BITS  = 2;

  // register indexes on the configuration port
  localparam logic [IDX_BITS-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_MAX_SIDE   = 2'd2;

  // reset register values, truncated to the dimension width
  localparam int RST_SRC_W_RAW = 480 % (1 << DIM_BITS);
  localparam int RST_SRC_H_RAW = 480 % (1 << DIM_BITS);
  localparam int RST_MAX_RAW   = 320 % (1 << DIM_BITS);

  localparam int RST_SW = (RST_SRC_W_RAW == 0) ? 1 : RST_SRC_W_RAW;
  localparam int RST_SH = (RST_SRC_H_RAW == 0) ? 1 : RST_SRC_H_RAW;
  localparam int RST_MS = (RST_MAX_RAW == 0) ? 1 : RST_MAX_RAW;

  localparam bit RST_NEED_FIT = (RST_SW > RST_MS) || (RST_SH > RST_MS);
  localparam bit RST_WIDE     = RST_SW >= RST_SH;

  localparam int RST_FIT_W_RAW = !RST_NEED_FIT ? RST_SW :
                                 (RST_WIDE ? RST_MS : (RST_SW * RST_MS) / RST_SH);
  localparam int RST_FIT_H_RAW = !RST_NEED_FIT ? RST_SH :
                                 (RST_WIDE ? (RST_SH * RST_MS) / RST_SW : RST_MS);
  localparam int RST_FIT_W = (RST_FIT_W_RAW == 0) ? 1 : RST_FIT_W_RAW;
  localparam int RST_FIT_H = (RST_FIT_H_RAW == 0) ? 1 : RST_FIT_H_RAW;

  localparam int RST_X_INC = (RST_SW << FRAC_BITS) / RST_FIT_W;
  localparam int RST_Y_INC = (RST_SH << FRAC_BITS) / RST_FIT_H;

  function automatic logic [DIM_BITS-1:0] at_least_one(input logic [DIM_BITS-1:0] v);
    at_least_one = (v == '0) ? {{(DIM_BITS-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nearest_neighbor_fit_downscaler_unit.sv
// Nearest-neighbour downscaler that fits an RGB565 frame within a maximum side.
// Depends on nnfd_pkg for widths, register indexes and reset scale values.
//
//  channel | dir | handshake      | fields
//  --------+-----+----------------+-------------------------------------------------------
//  s_axis  | in  | tvalid, tready | tdata pixel_in
//  m_axis  | out | tvalid, tready | tdata pixel_out + fit size, tlast row end, tuser frame end
//  cfg     | in  | cfg_we_i only  | cfg_idx_i, cfg_data_i; no wait
//
// A pixel per cycle outside setup and stalls; a selected pixel is on m_axis the cycle after.
// The scale setup (fit size and 12.16 steps) runs through one multiplier and a shared
// restoring divider, one quotient bit per cycle: multiply, fit division if needed, x step, y step.
// s_axis_tready is low during setup, which follows a register write made at the start of a
// frame, or the frame end after a write made mid-frame.
// Reset (rst_ni low, asynchronous) loads the reset registers and their scale values.
// m_axis stalls only hold the output register; a new pixel is taken when it is emptied.
`default_nettype none

module nearest_neighbor_fit_downscaler_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // s_axis_tdata: [15:0] pixel_in
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [nnfd_pkg::PIX_BITS-1:0]    s_axis_tdata,
  // m_axis_tdata: [15:0] pixel_out, [27:16] scaled_width, [39:28] scaled_height
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [nnfd_pkg::PIX_BITS+2*nnfd_pkg::DIM_BITS-1:0] m_axis_tdata,
  output      logic                             m_axis_tlast,
  // m_axis_tuser: [0] last_in_frame
  output      logic                             m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [nnfd_pkg::IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [nnfd_pkg::DIM_BITS-1:0]    cfg_data_i
);

  localparam int DW = nnfd_pkg::DIM_BITS;
  localparam int PW = nnfd_pkg::POS_BITS;
  localparam int FW = nnfd_pkg::FRAC_BITS;
  localparam int CW = nnfd_pkg::CNT_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_FIT  = 3'd2;
  localparam logic [2:0] ST_XINC = 3'd3;
  localparam logic [2:0] ST_YINC = 3'd4;

  localparam logic [CW-1:0] CNT_LAST = CW'(PW - 1);

  // configuration registers
  logic [DW-1:0] src_w_q, src_h_q, max_side_q;

  // derived scale state
  logic [DW-1:0] fit_w_q, fit_h_q;
  logic [PW-1:0] x_inc_q, y_inc_q;
  logic          dirty_q;

  // setup sequencer and divider
  logic [2:0]    state_q;
  logic [PW-1:0] div_num_q;
  logic [DW-1:0] div_rem_q, div_den_q;
  logic [CW-1:0] div_cnt_q;

  // position counters
  logic [DW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [DW-1:0] dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [PW-1:0] nx_q, nx_d, ny_q, ny_d;

  // output register
  logic                          out_valid_q;
  logic [nnfd_pkg::PIX_BITS-1:0] out_pix_q;
  logic                          out_lrow_q, out_lframe_q;
  logic [DW-1:0]                 out_w_q, out_h_q;

  logic [DW-1:0]   sw, sh, ms;
  logic            need_fit, wide;
  logic [2*DW-1:0] prod;
  logic [DW:0]     rem_sh;
  logic            div_ge;
  logic [DW-1:0]   rem_nx;
  logic [PW-1:0]   quo_nx;
  logic [DW-1:0]   fit_q1;
  logic            div_last;

  logic busy, accept, row_sel, col_sel, row_end, frame_end, hit, last_row, last_frame;
  logic cfg_reg_hit, cfg_at_start, start_derive;

  assign sw = nnfd_pkg::at_least_one(src_w_q);
  assign sh = nnfd_pkg::at_least_one(src_h_q);
  assign ms = nnfd_pkg::at_least_one(max_side_q);

  assign need_fit = (sw > ms) || (sh > ms);
  assign wide     = sw >= sh;
  assign prod     = (2*DW)'(wide ? sh : sw) * (2*DW)'(ms);

  // one restoring division step
  assign rem_sh   = {div_rem_q, div_num_q[PW-1]};
  assign div_ge   = rem_sh >= {1'b0, div_den_q};
  assign rem_nx   = div_ge ? DW'(rem_sh - {1'b0, div_den_q}) : rem_sh[DW-1:0];
  assign quo_nx   = {div_num_q[PW-2:0], div_ge};
  assign fit_q1   = nnfd_pkg::at_least_one(quo_nx[DW-1:0]);
  assign div_last = div_cnt_q == CNT_LAST;

  assign busy          = state_q != ST_IDLE;
  assign s_axis_tready = !busy && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign row_sel   = (dst_row_q < fit_h_q) && (ny_q[PW-1:FW] == src_row_q);
  assign col_sel   = (dst_col_q < fit_w_q) && (nx_q[PW-1:FW] == src_col_q);
  assign row_end   = src_col_q >= DW'(sw - 1'b1);
  assign frame_end = row_end && (src_row_q >= DW'(sh - 1'b1));
  assign hit       = row_sel && col_sel;
  assign last_row  = dst_col_q == DW'(fit_w_q - 1'b1);
  assign last_frame = last_row && (dst_row_q == DW'(fit_h_q - 1'b1));

  assign cfg_reg_hit  = cfg_we_i && (cfg_idx_i inside {nnfd_pkg::REG_SRC_WIDTH,
                                                       nnfd_pkg::REG_SRC_HEIGHT,
                                                       nnfd_pkg::REG_MAX_SIDE});
  assign cfg_at_start = (src_col_q == '0) && (src_row_q == '0);
  assign start_derive = (cfg_reg_hit && cfg_at_start) || (accept && frame_end && dirty_q);

  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    nx_d      = nx_q;
    ny_d      = ny_q;
    if (col_sel) begin
      dst_col_d = dst_col_q + 1'b1;
      nx_d      = nx_q + x_inc_q;
    end
    if (frame_end) begin
      src_col_d = '0;
      src_row_d = '0;
      dst_col_d = '0;
      dst_row_d = '0;
      nx_d      = '0;
      ny_d      = '0;
    end else if (row_end) begin
      src_col_d = '0;
      dst_col_d = '0;
      nx_d      = '0;
      if (row_sel) begin
        dst_row_d = dst_row_q + 1'b1;
        ny_d      = ny_q + y_inc_q;
      end
      src_row_d = src_row_q + 1'b1;
    end else begin
      src_col_d = src_col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= DW'(nnfd_pkg::RST_SRC_W_RAW);
      src_h_q    <= DW'(nnfd_pkg::RST_SRC_H_RAW);
      max_side_q <= DW'(nnfd_pkg::RST_MAX_RAW);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nnfd_pkg::REG_SRC_WIDTH:  src_w_q    <= cfg_data_i;
        nnfd_pkg::REG_SRC_HEIGHT: src_h_q    <= cfg_data_i;
        nnfd_pkg::REG_MAX_SIDE:   max_side_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a write made mid-frame takes effect on the scale values at the frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b0;
    end else if (accept && frame_end) begin
      dirty_q <= 1'b0;
    end else if (cfg_reg_hit && !cfg_at_start) begin
      dirty_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fit_w_q   <= DW'(nnfd_pkg::RST_FIT_W);
      fit_h_q   <= DW'(nnfd_pkg::RST_FIT_H);
      x_inc_q   <= PW'(nnfd_pkg::RST_X_INC);
      y_inc_q   <= PW'(nnfd_pkg::RST_Y_INC);
      div_num_q <= '0;
      div_rem_q <= '0;
      div_den_q <= '0;
      div_cnt_q <= '0;
    end else if (start_derive) begin
      state_q <= ST_MUL;
    end else begin
      case (state_q)
        ST_IDLE: ;
        ST_MUL: begin
          div_rem_q <= '0;
          div_cnt_q <= '0;
          if (need_fit) begin
            div_num_q <= PW'(prod);
            div_den_q <= wide ? sw : sh;
            state_q   <= ST_FIT;
          end else begin
            fit_w_q   <= sw;
            fit_h_q   <= sh;
            div_num_q <= {sw, {FW{1'b0}}};
            div_den_q <= sw;
            state_q   <= ST_XINC;
          end
        end
        ST_FIT, ST_XINC, ST_YINC: begin
          if (div_last) begin
            div_rem_q <= '0;
            div_cnt_q <= '0;
            case (state_q)
              ST_FIT: begin
                if (wide) begin
                  fit_w_q   <= ms;
                  fit_h_q   <= fit_q1;
                  div_den_q <= ms;
                end else begin
                  fit_w_q   <= fit_q1;
                  fit_h_q   <= ms;
                  div_den_q <= fit_q1;
                end
                div_num_q <= {sw, {FW{1'b0}}};
                state_q   <= ST_XINC;
              end
              ST_XINC: begin
                x_inc_q   <= quo_nx;
                div_num_q <= {sh, {FW{1'b0}}};
                div_den_q <= fit_h_q;
                state_q   <= ST_YINC;
              end
              default: begin
                y_inc_q <= quo_nx;
                state_q <= ST_IDLE;
              end
            endcase
          end else begin
            div_num_q <= quo_nx;
            div_rem_q <= rem_nx;
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      nx_q      <= '0;
      ny_q      <= '0;
    end else if (accept) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      nx_q      <= nx_d;
      ny_q      <= ny_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= accept && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      out_pix_q    <= s_axis_tdata;
      out_lrow_q   <= last_row;
      out_lframe_q <= last_frame;
      out_w_q      <= fit_w_q;
      out_h_q      <= fit_h_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_h_q, out_w_q, out_pix_q};
  assign m_axis_tlast  = out_lrow_q;
  assign m_axis_tuser  = out_lframe_q;

`ifndef SYNTHESIS
  a_no_take_in_setup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("pixel request taken during scale setup");

  a_frame_end_ends_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame end flagged without row end");

  a_fit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (fit_w_q != '0 && fit_h_q != '0))
    else $error("fit size is zero after setup");

  a_dst_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_col_q <= fit_w_q)
    else $error("output column ran past the fit width");

  a_setup_from_idle_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (src_col_q == '0 && src_row_q == '0))
    else $error("scale setup started mid-frame");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/nearest_neighbor_fit_downscaler_unit_tb.sv
// Self-checking bench for the nearest-neighbour fit downscaler: random RGB565 frames
// against an in-bench model of the fit size, 12.16 steps and pixel selection.
// Depends on nnfd_pkg and nearest_neighbor_fit_downscaler_unit.
module nearest_neighbor_fit_downscaler_unit_tb;
  import nnfd_pkg::*;

  localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PIXELS = 1550;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel;
    logic                row_last;
    logic                frame_last;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } out_pixel_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [PIX_BITS-1:0]            s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [PIX_BITS+2*DIM_BITS-1:0] m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;
  logic                           cfg_we_i = 1'b0;
  logic [IDX_BITS-1:0]            cfg_idx_i = '0;
  logic [DIM_BITS-1:0]            cfg_data_i = '0;

  logic [PIX_BITS-1:0] pixel_queue[$];
  out_pixel_t          awaited_pixels[$];
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  int                  mismatch_count = 0;

  // model state
  logic [DIM_BITS-1:0] reg_src_w, reg_src_h, reg_max_side;
  logic [DIM_BITS-1:0] in_col, in_row, out_col, out_row, fit_w, fit_h;
  logic [POS_BITS-1:0] next_x, next_y, step_x, step_y;

  nearest_neighbor_fit_downscaler_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [DIM_BITS-1:0] floor_one(input logic [DIM_BITS-1:0] v);
    return (v == '0) ? DIM_BITS'(1) : v;
  endfunction

  function automatic void update_scale();
    longint unsigned sw, sh, ms, w, h;
    sw = floor_one(reg_src_w);
    sh = floor_one(reg_src_h);
    ms = floor_one(reg_max_side);
    w = sw;
    h = sh;
    if (w > ms || h > ms) begin
      // longer side (width on a tie) becomes the limit
      if (w >= h) begin
        h = h * ms / w;
        w = ms;
      end else begin
        w = w * ms / h;
        h = ms;
      end
    end
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    fit_w  = w[DIM_BITS-1:0];
    fit_h  = h[DIM_BITS-1:0];
    step_x = POS_BITS'((sw << FRAC_BITS) / w);
    step_y = POS_BITS'((sh << FRAC_BITS) / h);
  endfunction

  function automatic void restart_frame();
    in_col  = '0;
    in_row  = '0;
    out_col = '0;
    out_row = '0;
    next_x  = '0;
    next_y  = '0;
    update_scale();
  endfunction

  function automatic void write_register(input logic [IDX_BITS-1:0] idx,
                                         input logic [DIM_BITS-1:0] val);
    case (idx)
      REG_SRC_WIDTH:  reg_src_w = val;
      REG_SRC_HEIGHT: reg_src_h = val;
      REG_MAX_SIDE:   reg_max_side = val;
      default:        return;
    endcase
    // mid-frame writes only take effect on the scale at the frame end
    if (in_col == '0 && in_row == '0) update_scale();
  endfunction

  function automatic void downscale_step(input logic [PIX_BITS-1:0] pixel, output bit hit,
                                         output out_pixel_t res);
    bit row_sel, col_sel, row_end, frame_end;
    row_sel   = out_row < fit_h && next_y[POS_BITS-1:FRAC_BITS] == in_row;
    col_sel   = out_col < fit_w && next_x[POS_BITS-1:FRAC_BITS] == in_col;
    row_end   = in_col >= floor_one(reg_src_w) - 1;
    frame_end = row_end && in_row >= floor_one(reg_src_h) - 1;
    hit = row_sel && col_sel;
    res = '0;
    if (hit) begin
      res.pixel      = pixel;
      res.row_last   = out_col == fit_w - 1;
      res.frame_last = res.row_last && out_row == fit_h - 1;
      res.width      = fit_w;
      res.height     = fit_h;
    end
    if (col_sel) begin
      out_col = out_col + 1'b1;
      next_x  = next_x + step_x;
    end
    if (frame_end) begin
      restart_frame();
    end else if (row_end) begin
      in_col  = '0;
      out_col = '0;
      next_x  = '0;
      if (row_sel) begin
        out_row = out_row + 1'b1;
        next_y  = next_y + step_y;
      end
      in_row = in_row + 1'b1;
    end else begin
      in_col = in_col + 1'b1;
    end
  endfunction

  // pixels still needed to close the current source frame, under the present registers
  function automatic int frame_remaining();
    int sw, sh, n;
    sw = floor_one(reg_src_w);
    sh = floor_one(reg_src_h);
    n = (in_col >= sw - 1) ? 1 : sw - in_col;
    if (in_row < sh - 1) n += (sh - 1 - in_row) * sw;
    return n;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // driver: one request per accepted handshake, gaps at random
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tdata  <= pixel_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // model side: register writes and accepted pixels
  always @(posedge clk_i) begin : model_update
    out_pixel_t want;
    bit         hit;
    if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
    if (s_axis_tvalid && s_axis_tready) begin
      downscale_step(s_axis_tdata, hit, want);
      if (hit) awaited_pixels.push_back(want);
    end
  end

  // monitor
  always @(posedge clk_i) begin : result_check
    out_pixel_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (awaited_pixels.size() == 0) begin
        $error("unexpected pixel %0h on output", m_axis_tdata[PIX_BITS-1:0]);
        mismatch_count++;
      end else begin
        want = awaited_pixels.pop_front();
        check_field("pixel_out", want.pixel, m_axis_tdata[PIX_BITS-1:0]);
        check_field("scaled_width", want.width, m_axis_tdata[PIX_BITS+DIM_BITS-1:PIX_BITS]);
        check_field("scaled_height", want.height,
                    m_axis_tdata[PIX_BITS+2*DIM_BITS-1:PIX_BITS+DIM_BITS]);
        check_field("last_in_row", want.row_last, m_axis_tlast);
        check_field("last_in_frame", want.frame_last, m_axis_tuser);
      end
    end
  end

  task automatic push_pixels(input int n);
    repeat (n) pixel_queue.push_back(PIX_BITS'($urandom_range(0, 65535)));
  endtask

  // all requests taken and all results back, plus a little slack for the pipeline
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixel_queue.size() != 0 || s_axis_tvalid || awaited_pixels.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= DIM_BITS'(val);
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int pick_dim(input int limit);
    return ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, limit);
  endfunction

  initial begin : stimulus
    int n;
    int random_items;
    random_items = 0;
    reg_src_w    = DIM_BITS'(480);
    reg_src_h    = DIM_BITS'(480);
    reg_max_side = DIM_BITS'(320);
    restart_frame();
    tx_idle_pct = 22;
    rx_idle_pct = 85;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset scale, extreme pixel values
    pixel_queue.push_back(16'h0000);
    pixel_queue.push_back(16'hFFFF);
    pixel_queue.push_back(16'h5555);
    wait_idle();
    // zero registers, written mid-frame
    write_reg(REG_SRC_WIDTH, 0);
    write_reg(REG_SRC_HEIGHT, 0);
    write_reg(REG_MAX_SIDE, 0);
    close_writes();
    pixel_queue.push_back(16'hAAAA);
    push_pixels(2);
    wait_idle();
    // largest frame, equal sizes: straight pass-through, then cut short
    write_reg(REG_SRC_WIDTH, 4095);
    write_reg(REG_SRC_HEIGHT, 4095);
    write_reg(REG_MAX_SIDE, 4095);
    close_writes();
    push_pixels(3);
    wait_idle();
    write_reg(REG_SRC_WIDTH, 3);
    write_reg(REG_SRC_HEIGHT, 2);
    close_writes();
    push_pixels(frame_remaining());
    wait_idle();
    // very wide source squeezed to one pixel; height rounds down to zero
    write_reg(REG_SRC_WIDTH, 4095);
    write_reg(REG_SRC_HEIGHT, 1);
    write_reg(REG_MAX_SIDE, 1);
    write_reg(REG_UNUSED, 4095);
    close_writes();
    push_pixels(2);
    wait_idle();
    write_reg(REG_SRC_WIDTH, 2);
    close_writes();
    push_pixels(frame_remaining());
    wait_idle();
    // single-column tall frame
    write_reg(REG_SRC_WIDTH, 1);
    write_reg(REG_SRC_HEIGHT, 4095);
    write_reg(REG_MAX_SIDE, 4095);
    close_writes();
    push_pixels(3);
    wait_idle();
    write_reg(REG_SRC_HEIGHT, 1);
    close_writes();
    push_pixels(frame_remaining());

    while (random_items < RANDOM_PIXELS) begin
      if (random_items < RANDOM_PIXELS / 3) begin
        tx_idle_pct = 22;
        rx_idle_pct = 85;
      end else if (random_items < 2 * RANDOM_PIXELS / 3) begin
        tx_idle_pct = 85;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_idle();
      if ($urandom_range(0, 99) < 70) write_reg(REG_SRC_WIDTH, pick_dim(20));
      if ($urandom_range(0, 99) < 70) write_reg(REG_SRC_HEIGHT, pick_dim(12));
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 9) == 0) write_reg(REG_MAX_SIDE, $urandom_range(0, 4095));
        else write_reg(REG_MAX_SIDE, pick_dim(24));
      end
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom_range(0, 4095));
      close_writes();
      n = frame_remaining();
      // mostly whole frames; now and then a frame broken off part way
      if (n > 1 && $urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, n - 1);
      end else begin
        n += $urandom_range(0, 2) * int'(floor_one(reg_src_w)) * int'(floor_one(reg_src_h));
      end
      push_pixels(n);
      random_items += n;
    end

    wait_idle();
    repeat (90) @(posedge clk_i);
    if (awaited_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", awaited_pixels.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("nearest_neighbor_fit_downscaler_unit_tb: done, clean");
    end else begin
      $display("nearest_neighbor_fit_downscaler_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("nearest_neighbor_fit_downscaler_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/nnfd_pkg.sv
hw/rtl/nearest_neighbor_fit_downscaler_unit.sv
tb/sv/nearest_neighbor_fit_downscaler_unit_tb.sv
